// File: sv/lpbt_pkg.sv
// ============================================================================
// lpbt_pkg
// Shared types and constants for the LRU page buffer tracker.
// ============================================================================
package lpbt_pkg;

    // Table size and stamp width.
    localparam int NUM_PAGES  = 64;
    localparam int STAMP_BITS = 32;

    // Derived widths.
    localparam int PAGE_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int COUNT_W = $clog2(NUM_PAGES + 1);

    // Fixed field widths.
    localparam int MODE_W  = 3;
    localparam int ID_W    = 12;
    localparam int LIMIT_W = 13;

    // Reset value of the page limit register.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SAVE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_QUERY = 3'd5;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } lpbt_state_t;

    // One input item.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   page_id;
    } lpbt_in_t;

    // One result item.
    typedef struct packed {
        logic               accepted;
        logic               victim_valid;
        logic [ID_W-1:0]    victim_page;
        logic               dirty;
        logic [LIMIT_W-1:0] open_count;
    } lpbt_out_t;

    // Status of the victim scan.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [PAGE_W-1:0] victim;
    } lpbt_scan_res_t;

endpackage

// File: sv/lpbt_stamp_ram.sv
// ============================================================================
// lpbt_stamp_ram
// Last-use stamp memory: one write port, one read port with registered data.
// ============================================================================
module lpbt_stamp_ram
    import lpbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  we,
    input  logic [PAGE_W-1:0]     waddr,
    input  logic [STAMP_BITS-1:0] wdata,
    input  logic [PAGE_W-1:0]     raddr,
    output logic [STAMP_BITS-1:0] rdata
);

    logic [STAMP_BITS-1:0] mem [NUM_PAGES];
    logic [STAMP_BITS-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/lpbt_victim_scan.sv
// ============================================================================
// lpbt_victim_scan
// Walks the stamp memory one entry per cycle and keeps the oldest candidate.
// ============================================================================
module lpbt_victim_scan
    import lpbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PAGE_W-1:0]     cur_page,
    input  logic [NUM_PAGES-1:0]  cand_mask,
    output logic [PAGE_W-1:0]     raddr,
    input  logic [STAMP_BITS-1:0] rdata,
    output lpbt_scan_res_t        result
);

    localparam logic [PAGE_W-1:0] LAST_IDX = PAGE_W'(NUM_PAGES - 1);

    logic                  active_reg,   active_next;
    logic [PAGE_W-1:0]     idx_reg,      idx_next;
    logic                  cmp_vld_reg,  cmp_vld_next;
    logic [PAGE_W-1:0]     cmp_idx_reg,  cmp_idx_next;
    logic                  last_reg,     last_next;
    logic                  done_reg,     done_next;
    logic                  found_reg,    found_next;
    logic [STAMP_BITS-1:0] best_reg,     best_next;
    logic [PAGE_W-1:0]     victim_reg,   victim_next;

    // Issue side: one read per cycle, candidate flag travels with the read.
    always_comb
    begin
        active_next  = active_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = idx_reg;
        last_next    = 1'b0;
        if (start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            cmp_vld_next = cand_mask[idx_reg] && (idx_reg != cur_page);
            last_next    = (idx_reg == LAST_IDX);
            if (idx_reg == LAST_IDX)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + PAGE_W'(1);
            end
        end
    end

    // Compare side: strict less-than keeps the lowest index on a tie.
    always_comb
    begin
        found_next  = found_reg;
        best_next   = best_reg;
        victim_next = victim_reg;
        done_next   = last_reg;
        if (start)
        begin
            found_next = 1'b0;
        end
        else if (cmp_vld_reg && (!found_reg || (rdata < best_reg)))
        begin
            found_next  = 1'b1;
            best_next   = rdata;
            victim_next = cmp_idx_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            cmp_vld_reg <= 1'b0;
            last_reg    <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            cmp_vld_reg <= cmp_vld_next;
            last_reg    <= last_next;
            done_reg    <= done_next;
            found_reg   <= found_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        best_reg    <= best_next;
        victim_reg  <= victim_next;
    end

    assign raddr         = idx_reg;
    assign result.done   = done_reg;
    assign result.found  = found_reg;
    assign result.victim = victim_reg;

endmodule

// File: sv/lru_page_buffer_tracker_core.sv
// Sequencer: each item is taken in idle, executed, and its result is loaded into the
// output register; an add or load that exceeds the page limit first runs a victim scan
// that reads one stamp per cycle. A new item is taken only once the last one is done;
// a result held by the receiver stalls the next item for as long as it waits.
// Reset clears all page marks, the use counter and the open count at once,
// and sets the page limit to 16; no clearing pass is needed.
// ============================================================================
// lru_page_buffer_tracker_core
// Page table with LRU victim selection driven by a small sequencer.
// ============================================================================
module lru_page_buffer_tracker_core
    import lpbt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpbt_in_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lpbt_out_t          out_data,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_data
);

    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
    localparam logic [COUNT_W-1:0]    COUNT_MAX = COUNT_W'(NUM_PAGES);
    localparam logic [ID_W:0]         ID_LIMIT  = (ID_W + 1)'(NUM_PAGES);

    lpbt_state_t state_reg, state_next;

    logic [LIMIT_W-1:0]    limit_reg;
    logic [NUM_PAGES-1:0]  present_reg;
    logic [NUM_PAGES-1:0]  in_mem_reg;
    logic [NUM_PAGES-1:0]  dirty_reg;
    logic [STAMP_BITS-1:0] counter_reg;
    logic [COUNT_W-1:0]    open_reg, open_next;

    logic [MODE_W-1:0]     mode_reg;
    logic [ID_W-1:0]       id_reg;
    logic                  acc_reg;
    logic                  qdirty_reg;
    logic                  vvalid_reg;
    logic [PAGE_W-1:0]     vpage_reg;
    logic                  out_valid_reg;
    lpbt_out_t             out_data_reg;

    logic                  item_ok;
    logic [PAGE_W-1:0]     page;
    logic                  is_open;
    logic                  is_stamp;
    logic                  over_limit;
    logic                  scan_start;
    logic                  stamp_we;
    logic                  out_load;
    logic                  exec_en;
    logic [PAGE_W-1:0]     scan_raddr;
    logic [STAMP_BITS-1:0] scan_rdata;
    lpbt_scan_res_t        scan_res;

    // Decode of the item being executed.
    assign page     = id_reg[PAGE_W-1:0];
    assign item_ok  = ({1'b0, id_reg} < ID_LIMIT) && (mode_reg <= MODE_QUERY);
    assign is_open  = (mode_reg == MODE_ADD) || (mode_reg == MODE_LOAD);
    assign is_stamp = is_open || (mode_reg == MODE_WRITE) || (mode_reg == MODE_READ);

    // Open count after this item, saturating at both ends.
    always_comb
    begin
        open_next = open_reg;
        if (item_ok)
        begin
            if (is_open && (open_reg != COUNT_MAX))
            begin
                open_next = open_reg + COUNT_W'(1);
            end
            else if ((mode_reg == MODE_SAVE) && (open_reg != '0))
            begin
                open_next = open_reg - COUNT_W'(1);
            end
        end
    end

    assign over_limit = (LIMIT_W'(open_next) > limit_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (item_ok && is_open && over_limit)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        exec_en    = 1'b0;
        scan_start = 1'b0;
        stamp_we   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                exec_en    = item_ok;
                stamp_we   = item_ok && is_stamp;
                scan_start = item_ok && is_open && over_limit;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Page marks, use counter, open count and page limit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= LIMIT_RESET;
            present_reg <= '0;
            in_mem_reg  <= '0;
            dirty_reg   <= '0;
            counter_reg <= '0;
            open_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (exec_en)
            begin
                open_reg <= open_next;
                if (is_stamp && (counter_reg != STAMP_MAX))
                begin
                    counter_reg <= counter_reg + STAMP_BITS'(1);
                end
                case (mode_reg)
                    MODE_ADD:
                    begin
                        present_reg[page] <= 1'b1;
                        in_mem_reg[page]  <= 1'b1;
                        dirty_reg[page]   <= 1'b1;
                    end
                    MODE_LOAD:
                    begin
                        in_mem_reg[page] <= 1'b1;
                        dirty_reg[page]  <= 1'b0;
                    end
                    MODE_SAVE:
                    begin
                        in_mem_reg[page] <= 1'b0;
                    end
                    MODE_WRITE:
                    begin
                        dirty_reg[page] <= 1'b1;
                    end
                    default:
                    begin
                        dirty_reg[page] <= dirty_reg[page];
                    end
                endcase
            end
        end
    end

    // Item and result holding registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= in_data.mode;
            id_reg   <= in_data.page_id;
        end
        if (state_reg == ST_EXEC)
        begin
            acc_reg    <= item_ok;
            qdirty_reg <= item_ok && (mode_reg == MODE_QUERY) && dirty_reg[page];
            vvalid_reg <= 1'b0;
            vpage_reg  <= '0;
        end
        if ((state_reg == ST_SCAN) && scan_res.done)
        begin
            vvalid_reg <= scan_res.found;
            vpage_reg  <= scan_res.found ? scan_res.victim : '0;
        end
        if (out_load)
        begin
            out_data_reg.accepted     <= acc_reg;
            out_data_reg.victim_valid <= vvalid_reg;
            out_data_reg.victim_page  <= ID_W'(vpage_reg);
            out_data_reg.dirty        <= qdirty_reg;
            out_data_reg.open_count   <= LIMIT_W'(open_reg);
        end
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Stamp memory. A page can only be a victim candidate after an add,
    // which always stamps it, so no stamp is compared before it is written.
    lpbt_stamp_ram u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (page),
        .wdata (counter_reg),
        .raddr (scan_raddr),
        .rdata (scan_rdata)
    );

    // Victim scan over present, in-memory pages.
    lpbt_victim_scan u_victim_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .cur_page  (page),
        .cand_mask (present_reg & in_mem_reg),
        .raddr     (scan_raddr),
        .rdata     (scan_rdata),
        .result    (scan_res)
    );

endmodule

// File: tb/sv/lru_page_buffer_tracker_core_test.sv
// ============================================================================
// lru_page_buffer_tracker_core_test
// Self-checking bench for the LRU page buffer tracker. A driver sends page
// events from a queue; every accepted event runs through a behavioral copy of
// the page table that predicts its result. A monitor compares each result
// transfer field by field against the oldest prediction. The page limit is
// changed between phases while the block is idle.
// ============================================================================
module lru_page_buffer_tracker_core_test;
    import lpbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int IDLE_PCT       = 19;
    localparam int SETTLE_CYCLES  = NUM_PAGES + 10;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_REPORTS    = 10;

    // Modes the block does not define; they must be rejected.
    localparam logic [MODE_W-1:0] MODE_RSVD_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD_B = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    lpbt_in_t           in_data;
    logic               out_valid;
    logic               out_ready;
    lpbt_out_t          out_data;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_data;

    // Events waiting to be sent and results waiting to arrive.
    lpbt_in_t  page_events[$];
    lpbt_out_t expected_results[$];

    int events_sent    = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    // Shadow copy of the page table.
    logic                  pg_present[NUM_PAGES];
    logic                  pg_in_mem[NUM_PAGES];
    logic                  pg_dirty[NUM_PAGES];
    logic [STAMP_BITS-1:0] pg_stamp[NUM_PAGES];
    logic [STAMP_BITS-1:0] use_clock;
    int                    open_n;
    logic [LIMIT_W-1:0]    page_limit;

    lru_page_buffer_tracker_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Give a page the current use stamp; the clock stops at its top value.
    function automatic void stamp_page(int p);
        pg_stamp[p] = use_clock;
        if (use_clock != '1)
            use_clock = use_clock + 1'b1;
    endfunction

    // Apply one event to the shadow table and return the result it yields.
    function automatic lpbt_out_t predict_page_event(lpbt_in_t ev);
        lpbt_out_t             r;
        int                    p;
        logic                  seek;
        logic                  found;
        logic [STAMP_BITS-1:0] best;
        r = '0;
        seek = 1'b0;
        if (ev.page_id < NUM_PAGES && ev.mode <= MODE_QUERY)
        begin
            p = int'(ev.page_id);
            r.accepted = 1'b1;
            case (ev.mode)
                MODE_ADD:
                begin
                    pg_present[p] = 1'b1;
                    pg_in_mem[p] = 1'b1;
                    pg_dirty[p] = 1'b1;
                    stamp_page(p);
                    if (open_n < NUM_PAGES)
                        open_n++;
                    seek = 1'b1;
                end
                MODE_LOAD:
                begin
                    pg_in_mem[p] = 1'b1;
                    pg_dirty[p] = 1'b0;
                    stamp_page(p);
                    if (open_n < NUM_PAGES)
                        open_n++;
                    seek = 1'b1;
                end
                MODE_SAVE:
                begin
                    pg_in_mem[p] = 1'b0;
                    if (open_n > 0)
                        open_n--;
                end
                MODE_WRITE:
                begin
                    stamp_page(p);
                    pg_dirty[p] = 1'b1;
                end
                MODE_READ:
                    stamp_page(p);
                default:
                    r.dirty = pg_dirty[p];
            endcase
            // Over the limit: oldest other resident page, lowest index on a tie.
            if (seek && open_n > int'(page_limit))
            begin
                found = 1'b0;
                best = '0;
                for (int i = 0; i < NUM_PAGES; i++)
                begin
                    if (i != p && pg_present[i] && pg_in_mem[i]
                        && (!found || pg_stamp[i] < best))
                    begin
                        found = 1'b1;
                        best = pg_stamp[i];
                        r.victim_page = ID_W'(i);
                    end
                end
                r.victim_valid = found;
            end
        end
        r.open_count = LIMIT_W'(open_n);
        return r;
    endfunction

    // Random event: mostly in-range pages with legal modes, some rejects.
    function automatic lpbt_in_t random_page_event(int save_pct, int page_hi);
        lpbt_in_t ev;
        int       roll;
        roll = $urandom_range(99, 0);
        ev.page_id = ID_W'($urandom_range(page_hi, 0));
        if (roll < 4)
        begin
            ev.mode = MODE_W'($urandom_range(7, 0));
            ev.page_id = ID_W'($urandom_range(4095, NUM_PAGES));
        end
        else if (roll < 7)
            ev.mode = $urandom_range(1, 0) ? MODE_RSVD_A : MODE_RSVD_B;
        else if ($urandom_range(99, 0) < save_pct)
            ev.mode = MODE_SAVE;
        else
        begin
            case ($urandom_range(4, 0))
                0:       ev.mode = MODE_ADD;
                1:       ev.mode = MODE_LOAD;
                2:       ev.mode = MODE_WRITE;
                3:       ev.mode = MODE_READ;
                default: ev.mode = MODE_QUERY;
            endcase
        end
        return ev;
    endfunction

    function automatic lpbt_in_t page_event(logic [MODE_W-1:0] m, int id);
        lpbt_in_t ev;
        ev.mode = m;
        ev.page_id = ID_W'(id);
        return ev;
    endfunction

    // Wait until nothing is queued, in flight or outstanding, then settle.
    // The check runs at the falling edge, when the driver's updates have landed.
    task automatic wait_quiet();
        while (page_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_page_limit(int value);
        cfg_we <= 1'b1;
        cfg_data <= LIMIT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        page_limit = LIMIT_W'(value);
    endtask

    task automatic random_phase(int limit, int count, int save_pct, int page_hi);
        wait_quiet();
        write_page_limit(limit);
        repeat (count) page_events.push_back(random_page_event(save_pct, page_hi));
    endtask

    // Driver: sends the next event once the current transfer has completed.
    always @(posedge clk or negedge rst_n)
    begin
        lpbt_in_t next_item;
        logic     next_valid;
        logic     calm;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            next_valid = in_valid;
            next_item = in_data;
            calm = (events_sent >= 500 && events_sent < 700);
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_page_event(in_data));
                events_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid && page_events.size() != 0
                && (calm || $urandom_range(99, 0) >= IDLE_PCT))
            begin
                next_item = page_events.pop_front();
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
            in_data <= next_item;
        end
    end

    // Monitor: checks each result transfer and throttles the output side.
    always @(posedge clk or negedge rst_n)
    begin
        lpbt_out_t want;
        logic      calm;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result %0d arrived with nothing outstanding",
                                 $realtime, results_seen);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.accepted !== want.accepted
                        || out_data.victim_valid !== want.victim_valid
                        || out_data.victim_page !== want.victim_page
                        || out_data.dirty !== want.dirty
                        || out_data.open_count !== want.open_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $write("%0t: result %0d differs: expected acc=%0b vv=%0b ",
                                   $realtime, results_seen, want.accepted,
                                   want.victim_valid);
                            $write("vp=%0d dirty=%0b open=%0d, ", want.victim_page,
                                   want.dirty, want.open_count);
                            $display("got acc=%0b vv=%0b vp=%0d dirty=%0b open=%0d",
                                     out_data.accepted, out_data.victim_valid,
                                     out_data.victim_page, out_data.dirty,
                                     out_data.open_count);
                        end
                    end
                end
                // One long back-pressure window so the input side stalls.
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            calm = (results_seen >= 800 && results_seen < 1000);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || $urandom_range(99, 0) >= IDLE_PCT;
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus: directed corner cases, then random phases at several limits.
    initial
    begin
        for (int i = 0; i < NUM_PAGES; i++)
        begin
            pg_present[i] = 1'b0;
            pg_in_mem[i] = 1'b0;
            pg_dirty[i] = 1'b0;
            pg_stamp[i] = '0;
        end
        use_clock = '0;
        open_n = 0;
        page_limit = LIMIT_RESET;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_data <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Limit zero: the first add has no other page to evict.
        write_page_limit(0);
        page_events.push_back(page_event(MODE_QUERY, 0));
        page_events.push_back(page_event(MODE_SAVE, 5));
        page_events.push_back(page_event(MODE_ADD, 0));
        page_events.push_back(page_event(MODE_ADD, NUM_PAGES - 1));
        page_events.push_back(page_event(MODE_LOAD, 10));
        page_events.push_back(page_event(MODE_WRITE, 0));
        page_events.push_back(page_event(MODE_READ, NUM_PAGES - 1));
        page_events.push_back(page_event(MODE_QUERY, 0));
        page_events.push_back(page_event(MODE_QUERY, 10));
        page_events.push_back(page_event(MODE_LOAD, 0));
        page_events.push_back(page_event(MODE_QUERY, 0));
        page_events.push_back(page_event(MODE_SAVE, NUM_PAGES - 1));
        page_events.push_back(page_event(MODE_ADD, NUM_PAGES));
        page_events.push_back(page_event(MODE_READ, 4095));
        page_events.push_back(page_event(MODE_WRITE, NUM_PAGES));
        page_events.push_back(page_event(MODE_RSVD_A, 1));
        page_events.push_back(page_event(MODE_RSVD_B, NUM_PAGES - 1));
        page_events.push_back(page_event(MODE_ADD, 5));
        page_events.push_back(page_event(MODE_ADD, 6));
        page_events.push_back(page_event(MODE_SAVE, 0));
        page_events.push_back(page_event(MODE_SAVE, 5));
        page_events.push_back(page_event(MODE_QUERY, 4095));

        random_phase(LIMIT_RESET, 150, 30, NUM_PAGES - 1);
        random_phase(1, 150, 35, 15);
        random_phase(NUM_PAGES - 1, 150, 12, NUM_PAGES - 1);
        random_phase(NUM_PAGES, 140, 12, NUM_PAGES - 1);
        random_phase(4096, 130, 25, NUM_PAGES - 1);
        random_phase(2, 150, 35, 7);
        random_phase($urandom_range(4096, 0), 140, 30, NUM_PAGES - 1);
        random_phase(0, 120, 40, 31);
        wait_quiet();

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
sv/lpbt_pkg.sv
sv/lpbt_stamp_ram.sv
sv/lpbt_victim_scan.sv
sv/lru_page_buffer_tracker_core.sv
tb/sv/lru_page_buffer_tracker_core_test.sv
